// ===== design/esdc_pkg.sv =====
// Shared types and constants of the entity state delta codec.
// Request, response and queued command layouts, action codes and queue sizing.
// No dependencies.
`default_nettype none

package esdc_pkg;

	localparam int NUM_VALUES  = 7;
	localparam int VALUE_W     = 32;
	localparam int ROW_W       = NUM_VALUES * VALUE_W;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [2:0] ACT_ENCODE    = 3'd0;
	localparam logic [2:0] ACT_DECODE    = 3'd1;
	localparam logic [2:0] ACT_FORCE_ONE = 3'd2;
	localparam logic [2:0] ACT_FORCE_ALL = 3'd3;
	localparam logic [2:0] ACT_REMOVE    = 3'd4;
	localparam logic [2:0] ACT_CLEAR     = 3'd5;

	typedef enum logic [2:0] {
		OP_ENCODE    = 3'd0,
		OP_DECODE    = 3'd1,
		OP_FORCE_ONE = 3'd2,
		OP_FORCE_ALL = 3'd3,
		OP_REMOVE    = 3'd4,
		OP_CLEAR     = 3'd5
	} op_t;

	typedef struct packed {
		logic [2:0]         action;
		logic [7:0]         entity_id;
		logic [31:0]        tick;
		logic               is_keyframe;
		logic               last_of_frame;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic signed [31:0] yaw;
	} req_t;

	typedef struct packed {
		logic               from_decode;
		logic [7:0]         out_entity;
		logic [31:0]        out_tick;
		logic               out_keyframe;
		logic signed [31:0] out_pos_x;
		logic signed [31:0] out_pos_y;
		logic signed [31:0] out_pos_z;
		logic signed [31:0] out_vel_x;
		logic signed [31:0] out_vel_y;
		logic signed [31:0] out_vel_z;
		logic signed [31:0] out_yaw;
	} rsp_t;

	typedef struct packed {
		op_t  op;
		req_t item;
	} cmd_t;

endpackage

`default_nettype wire

// ===== design/esdc_front.sv =====
// Front end of the codec: takes request beats and turns them into queued commands.
// Drops unused action codes, and out-of-range entity ids on per-entity actions. Uses esdc_pkg.
`default_nettype none

module esdc_front #(
	parameter int MAX_ENTITIES = 256
) (
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire esdc_pkg::req_t req,
	input  wire logic          q_full,
	output logic               q_push,
	output esdc_pkg::cmd_t     q_wdata
);

	logic        id_ok;
	logic        keep;
	esdc_pkg::op_t op;

	assign id_ok = ({9'd0, req.entity_id} < 17'(MAX_ENTITIES));

	always_comb begin
		keep = 1'b0;
		op   = esdc_pkg::OP_ENCODE;
		case (req.action)
			esdc_pkg::ACT_ENCODE: begin
				op   = esdc_pkg::OP_ENCODE;
				keep = id_ok;
			end
			esdc_pkg::ACT_DECODE: begin
				op   = esdc_pkg::OP_DECODE;
				keep = id_ok;
			end
			esdc_pkg::ACT_FORCE_ONE: begin
				op   = esdc_pkg::OP_FORCE_ONE;
				keep = id_ok;
			end
			esdc_pkg::ACT_FORCE_ALL: begin
				op   = esdc_pkg::OP_FORCE_ALL;
				keep = 1'b1;
			end
			esdc_pkg::ACT_REMOVE: begin
				op   = esdc_pkg::OP_REMOVE;
				keep = id_ok;
			end
			esdc_pkg::ACT_CLEAR: begin
				op   = esdc_pkg::OP_CLEAR;
				keep = 1'b1;
			end
			default: begin
				op   = esdc_pkg::OP_ENCODE;
				keep = 1'b0;
			end
		endcase
	end

	// A beat that does nothing is still taken, it just never reaches the queue.
	assign req_ready    = !q_full;
	assign q_push       = req_valid && !q_full && keep;
	assign q_wdata.op   = op;
	assign q_wdata.item = req;

endmodule

`default_nettype wire

// ===== design/esdc_queue.sv =====
// Short command queue between the front and back ends of the codec.
// Flip-flop storage of esdc_pkg::QUEUE_DEPTH entries. Uses esdc_pkg.
`default_nettype none

module esdc_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire esdc_pkg::cmd_t wdata,
	output logic                full,
	input  wire logic           pop,
	output esdc_pkg::cmd_t      rdata,
	output logic                empty
);

	localparam int PTR_W = (esdc_pkg::QUEUE_DEPTH > 1) ? $clog2(esdc_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(esdc_pkg::QUEUE_DEPTH + 1);

	esdc_pkg::cmd_t    slot_q [esdc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full  = (count_q == CNT_W'(esdc_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(esdc_pkg::QUEUE_DEPTH - 1)) ? '0 :
					wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(esdc_pkg::QUEUE_DEPTH - 1)) ? '0 :
					rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ===== design/esdc_back.sv =====
// Back end of the codec: entity table, keyframe decision, delta arithmetic and response register.
// Holds valid and force bits in flops, tick and baseline rows in memories. Uses esdc_pkg.
`default_nettype none

module esdc_back #(
	parameter int MAX_ENTITIES = 256
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [31:0]    interval,
	input  wire esdc_pkg::cmd_t head,
	input  wire logic           q_empty,
	output logic                q_pop,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output esdc_pkg::rsp_t      rsp
);

	// Entity ids are 8 bits, so no more than 256 entries can ever be addressed.
	localparam int DEPTH = (MAX_ENTITIES < 256) ? MAX_ENTITIES : 256;
	localparam int IDX_W = $clog2(DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t                          state_q;
	logic [DEPTH-1:0]                valid_q;
	logic [DEPTH-1:0]                force_q;
	logic                            force_all_q;
	logic                            rsp_valid_q;
	esdc_pkg::rsp_t                  rsp_q;

	logic [esdc_pkg::ROW_W-1:0]      base_mem [DEPTH];
	logic [31:0]                     tick_mem [DEPTH];
	logic [esdc_pkg::ROW_W-1:0]      base_rd_q;
	logic [31:0]                     tick_rd_q;
	esdc_pkg::cmd_t                  cmd_s1;

	logic [IDX_W-1:0]                head_idx;
	logic [IDX_W-1:0]                idx_s1;
	logic                            head_mem_op;
	logic                            start;
	logic                            is_enc;
	logic                            key_in;
	logic                            ent_valid;
	logic                            ent_force;
	logic [31:0]                     due_tick;
	logic                            due;
	logic                            key_enc;
	logic                            emit;
	logic                            exec_done;
	logic [esdc_pkg::ROW_W-1:0]      in_vals;
	logic [esdc_pkg::ROW_W-1:0]      diff_vals;
	logic [esdc_pkg::ROW_W-1:0]      sum_vals;
	logic [esdc_pkg::ROW_W-1:0]      new_base;
	logic [esdc_pkg::ROW_W-1:0]      out_vals;
	esdc_pkg::rsp_t                  rsp_next;

	assign head_idx    = head.item.entity_id[IDX_W-1:0];
	assign idx_s1      = cmd_s1.item.entity_id[IDX_W-1:0];
	assign head_mem_op = (head.op == esdc_pkg::OP_ENCODE) || (head.op == esdc_pkg::OP_DECODE);
	assign q_pop       = (state_q == ST_IDLE) && !q_empty;
	assign start       = q_pop && head_mem_op;

	assign is_enc    = (cmd_s1.op == esdc_pkg::OP_ENCODE);
	assign key_in    = cmd_s1.item.is_keyframe;
	assign ent_valid = valid_q[idx_s1];
	assign ent_force = force_q[idx_s1];
	assign due_tick  = tick_rd_q + interval;
	assign due       = (cmd_s1.item.tick >= due_tick);
	assign key_enc   = force_all_q || !ent_valid || ent_force || due;
	// A decode delta for an entity that is not in the table produces nothing.
	assign emit      = is_enc || key_in || ent_valid;
	assign exec_done = (state_q == ST_EXEC) && (!emit || !rsp_valid_q || rsp_ready);

	assign in_vals = {cmd_s1.item.yaw, cmd_s1.item.vel_z, cmd_s1.item.vel_y,
		cmd_s1.item.vel_x, cmd_s1.item.pos_z, cmd_s1.item.pos_y, cmd_s1.item.pos_x};

	always_comb begin
		for (int k = 0; k < esdc_pkg::NUM_VALUES; k++) begin
			diff_vals[k*esdc_pkg::VALUE_W +: esdc_pkg::VALUE_W] =
				in_vals[k*esdc_pkg::VALUE_W +: esdc_pkg::VALUE_W] -
				base_rd_q[k*esdc_pkg::VALUE_W +: esdc_pkg::VALUE_W];
			sum_vals[k*esdc_pkg::VALUE_W +: esdc_pkg::VALUE_W] =
				in_vals[k*esdc_pkg::VALUE_W +: esdc_pkg::VALUE_W] +
				base_rd_q[k*esdc_pkg::VALUE_W +: esdc_pkg::VALUE_W];
		end
	end

	assign new_base = (is_enc || key_in) ? in_vals : sum_vals;
	assign out_vals = is_enc ? (key_enc ? in_vals : diff_vals) : new_base;

	always_comb begin
		rsp_next.from_decode  = !is_enc;
		rsp_next.out_entity   = cmd_s1.item.entity_id;
		rsp_next.out_tick     = cmd_s1.item.tick;
		rsp_next.out_keyframe = is_enc ? key_enc : key_in;
		rsp_next.out_pos_x    = out_vals[0*esdc_pkg::VALUE_W +: esdc_pkg::VALUE_W];
		rsp_next.out_pos_y    = out_vals[1*esdc_pkg::VALUE_W +: esdc_pkg::VALUE_W];
		rsp_next.out_pos_z    = out_vals[2*esdc_pkg::VALUE_W +: esdc_pkg::VALUE_W];
		rsp_next.out_vel_x    = out_vals[3*esdc_pkg::VALUE_W +: esdc_pkg::VALUE_W];
		rsp_next.out_vel_y    = out_vals[4*esdc_pkg::VALUE_W +: esdc_pkg::VALUE_W];
		rsp_next.out_vel_z    = out_vals[5*esdc_pkg::VALUE_W +: esdc_pkg::VALUE_W];
		rsp_next.out_yaw      = out_vals[6*esdc_pkg::VALUE_W +: esdc_pkg::VALUE_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			force_q     <= '0;
			force_all_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				case (head.op)
					esdc_pkg::OP_ENCODE, esdc_pkg::OP_DECODE: begin
						state_q <= ST_EXEC;
					end
					esdc_pkg::OP_FORCE_ONE: begin
						if (valid_q[head_idx]) begin
							force_q[head_idx] <= 1'b1;
						end
					end
					esdc_pkg::OP_FORCE_ALL: begin
						force_all_q <= 1'b1;
						force_q     <= force_q | valid_q;
					end
					esdc_pkg::OP_REMOVE: begin
						valid_q[head_idx] <= 1'b0;
						force_q[head_idx] <= 1'b0;
					end
					esdc_pkg::OP_CLEAR: begin
						valid_q     <= '0;
						force_q     <= '0;
						force_all_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (exec_done) begin
				state_q <= ST_IDLE;
				if (is_enc) begin
					if (key_enc) begin
						valid_q[idx_s1] <= 1'b1;
						force_q[idx_s1] <= 1'b0;
					end
					if (cmd_s1.item.last_of_frame) begin
						force_all_q <= 1'b0;
					end
				end else if (key_in) begin
					valid_q[idx_s1] <= 1'b1;
				end
			end
			if (exec_done && emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_s1    <= head;
			base_rd_q <= base_mem[head_idx];
			tick_rd_q <= tick_mem[head_idx];
		end
		if (exec_done && emit) begin
			base_mem[idx_s1] <= new_base;
			rsp_q            <= rsp_next;
		end
		if (exec_done && (is_enc ? key_enc : key_in)) begin
			tick_mem[idx_s1] <= cmd_s1.item.tick;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== design/entity_state_delta_codec.sv =====
// Entity state keyframe/delta codec. An encode or decode beat goes from the queue through the
// registered table read to the response register; the back end handles it in an idle and an
// execute state (compute and write back to the same row), waiting while a held response is
// not taken. Force, remove and clear end on the pop. Reset clears the valid and force bits and
// force-all at once and sets the interval to 1; tick and baseline memories are not cleared.
`default_nettype none

module entity_state_delta_codec #(
	parameter int MAX_ENTITIES = 256
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire esdc_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output esdc_pkg::rsp_t      rsp,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [31:0]    cfg_data
);

	logic [31:0]    interval_q;
	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_empty;
	esdc_pkg::cmd_t q_wdata;
	esdc_pkg::cmd_t q_rdata;

	assign cfg_ready = 1'b1;

	// An interval of zero behaves as one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= 32'd1;
		end else if (cfg_valid) begin
			interval_q <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
		end
	end

	esdc_front #(
		.MAX_ENTITIES(MAX_ENTITIES)
	) u_front (
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	esdc_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	esdc_back #(
		.MAX_ENTITIES(MAX_ENTITIES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.interval (interval_q),
		.head     (q_rdata),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command queue read while empty");

	a_interval_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		interval_q != 32'd0)
		else $error("keyframe interval register holds zero");
`endif

endmodule

`default_nettype wire
